// File: src/fbrn_pkg.sv
// ----------------------------------------------------------------------------
// fbrn_pkg
// Shared widths, codes and types of the feedback rate normalizer.
// ----------------------------------------------------------------------------
package fbrn_pkg;

    localparam int RAW_W     = 64;
    localparam int FB_W      = 6;
    localparam int IRATE_W   = 13;
    localparam int SCALE_W   = 32;
    localparam int RATE_W    = 64;
    localparam int Q_FRAC    = 32;
    localparam int APB_AW    = 6;
    localparam int APB_DW    = 64;
    localparam int REG_IDX_W = 3;

    localparam logic [IRATE_W-1:0] RATE_LIMIT = 13'd8000;

    // raw * source rate * scale_num
    localparam int RS_W  = RAW_W + IRATE_W;
    localparam int MA_W  = RS_W + SCALE_W;
    // audio rate * scale_den, then shifted by up to 63 fraction bits
    localparam int DA_W  = IRATE_W + SCALE_W;
    localparam int DEN_W = DA_W + (2 ** FB_W) - 1;
    localparam int NUM_W = MA_W + Q_FRAC;

    localparam int MUL_STEPS = SCALE_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_INVALID  = 2'd1,
        STAT_RANGE    = 2'd2,
        STAT_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FRAC_BITS = 3'd0,
        REG_SRC_RATE  = 3'd1,
        REG_AUD_RATE  = 3'd2,
        REG_SCALE_NUM = 3'd3,
        REG_SCALE_DEN = 3'd4,
        REG_MAX_RATE  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [FB_W-1:0]    fraction_bits;
        logic [IRATE_W-1:0] source_interval_rate;
        logic [IRATE_W-1:0] audio_interval_rate;
        logic [SCALE_W-1:0] scale_num;
        logic [SCALE_W-1:0] scale_den;
        logic [RATE_W-1:0]  max_rate;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SETUP,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_init;
        logic div_step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic pre_fail;
    } t_dp_stat;

endpackage

// File: src/feedback_rate_normalizer.sv
// ----------------------------------------------------------------------------
// feedback_rate_normalizer
// Converts a raw fixed-point feedback value to a Q32.32 frames-per-interval
// rate with argument, overflow and range checks.
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  input     start & !busy                i_raw_value[63:0]
//  result    o_valid (one-cycle strobe)   o_rate_q32[63:0], o_status[1:0]
//  config    psel & penable & pwrite      paddr[5:0], pwdata[63:0] (8-byte regs)
//
//  a transaction runs from accept to the next possible accept:
//  32 shift-add multiply steps, 1 divisor setup, 141 restoring divide steps
//  (one quotient bit per cycle), then the finish state and the result strobe
//  failed argument checks skip from the multiply state straight to finish
//  busy drops in the cycle the result strobe is high; a new start is taken then
//  synchronous active-low reset restores register defaults and idles the block
//  results cannot be stalled
// ----------------------------------------------------------------------------
module feedback_rate_normalizer import fbrn_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [RAW_W-1:0]  i_raw_value,
    output logic              o_valid,
    output logic [RATE_W-1:0] o_rate_q32,
    output logic [1:0]        o_status,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg     cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    fbrn_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fbrn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    fbrn_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (cfg),
        .i_raw_value (i_raw_value),
        .o_stat      (stat),
        .o_valid     (o_valid),
        .o_rate_q32  (o_rate_q32),
        .o_status    (o_status)
    );

endmodule

// File: src/fbrn_regs.sv
// ----------------------------------------------------------------------------
// fbrn_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module fbrn_regs import fbrn_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:APB_AW-REG_IDX_W]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fraction_bits        <= FB_W'(16);
            r_cfg.source_interval_rate <= IRATE_W'(1000);
            r_cfg.audio_interval_rate  <= IRATE_W'(1000);
            r_cfg.scale_num            <= SCALE_W'(1);
            r_cfg.scale_den            <= SCALE_W'(1);
            r_cfg.max_rate             <= '1;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FRAC_BITS: r_cfg.fraction_bits        <= pwdata[FB_W-1:0];
                REG_SRC_RATE:  r_cfg.source_interval_rate <= pwdata[IRATE_W-1:0];
                REG_AUD_RATE:  r_cfg.audio_interval_rate  <= pwdata[IRATE_W-1:0];
                REG_SCALE_NUM: r_cfg.scale_num            <= pwdata[SCALE_W-1:0];
                REG_SCALE_DEN: r_cfg.scale_den            <= pwdata[SCALE_W-1:0];
                REG_MAX_RATE:  r_cfg.max_rate             <= pwdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FRAC_BITS: prdata = APB_DW'(r_cfg.fraction_bits);
            REG_SRC_RATE:  prdata = APB_DW'(r_cfg.source_interval_rate);
            REG_AUD_RATE:  prdata = APB_DW'(r_cfg.audio_interval_rate);
            REG_SCALE_NUM: prdata = APB_DW'(r_cfg.scale_num);
            REG_SCALE_DEN: prdata = APB_DW'(r_cfg.scale_den);
            REG_MAX_RATE:  prdata = APB_DW'(r_cfg.max_rate);
            default:       prdata = '0;
        endcase
    end

endmodule

// File: src/fbrn_ctrl.sv
// ----------------------------------------------------------------------------
// fbrn_ctrl
// Sequencer: operand load, shift-add multiply, restoring divide, finish.
// ----------------------------------------------------------------------------
module fbrn_ctrl import fbrn_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_dp_stat i_stat,
    output logic     busy,
    output t_dp_cmd  o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                // failed argument checks skip the arithmetic
                if (i_stat.pre_fail) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.mul_step = 1'b1;
                    n_cnt          = r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

    a_setup_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETUP) |-> ($past(r_state) == S_MUL &&
                                  $past(r_cnt) == CNT_W'(MUL_STEPS - 1)))
        else $error("divide setup entered before multiply completed");

    a_fin_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && $past(r_state) == S_DIV) |->
            ($past(r_cnt) == CNT_W'(DIV_STEPS - 1)))
        else $error("divide ended early");

endmodule

// File: src/fbrn_dp.sv
// ----------------------------------------------------------------------------
// fbrn_dp
// Datapath: argument checks, serial multiplies, restoring divide, rounding.
// ----------------------------------------------------------------------------
module fbrn_dp import fbrn_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  t_cfg              i_cfg,
    input  logic [RAW_W-1:0]  i_raw_value,
    output t_dp_stat          o_stat,
    output logic              o_valid,
    output logic [RATE_W-1:0] o_rate_q32,
    output logic [1:0]        o_status
);

    logic [MA_W-1:0]    r_ma, r_acc_n;
    logic [SCALE_W-1:0] r_sn, r_sd;
    logic [DA_W-1:0]    r_da, r_acc_d;
    t_status            r_pre_st;
    logic [DEN_W-1:0]   r_den, r_rem;
    logic [NUM_W-1:0]   r_num;
    logic [RATE_W-1:0]  r_q;
    logic               r_qovf;
    logic               r_valid;
    logic [RATE_W-1:0]  r_rate;
    t_status            r_status;

    logic [RS_W-1:0]    raw_src;
    t_status            pre_st;
    logic [DEN_W:0]     sh, diff, twice;
    logic               ge;
    logic               round_up;
    logic [RATE_W:0]    q_round;
    t_status            fin_st;
    logic [RATE_W-1:0]  fin_rate;

    assign raw_src = i_raw_value * i_cfg.source_interval_rate;

    always_comb begin
        if (i_raw_value == '0 || i_cfg.source_interval_rate == '0 ||
            i_cfg.audio_interval_rate == '0 || i_cfg.scale_num == '0 ||
            i_cfg.scale_den == '0) begin
            pre_st = STAT_INVALID;
        end else if (i_cfg.source_interval_rate > RATE_LIMIT ||
                     i_cfg.audio_interval_rate > RATE_LIMIT) begin
            pre_st = STAT_RANGE;
        end else begin
            pre_st = STAT_OK;
        end
    end

    // one restoring divide step per cycle, numerator bits enter msb first
    assign sh   = {r_rem, r_num[NUM_W-1]};
    assign diff = sh - {1'b0, r_den};
    assign ge   = (sh >= {1'b0, r_den});

    assign twice    = {r_rem, 1'b0};
    assign round_up = (twice >= {1'b0, r_den});
    assign q_round  = {1'b0, r_q} + (RATE_W + 1)'(round_up);

    always_comb begin
        fin_rate = '0;
        if (r_pre_st != STAT_OK) begin
            fin_st = r_pre_st;
        end else if (r_qovf || q_round[RATE_W]) begin
            fin_st = STAT_OVERFLOW;
        end else if (q_round[RATE_W-1:0] == '0 ||
                     q_round[RATE_W-1:0] > i_cfg.max_rate) begin
            fin_st = STAT_RANGE;
        end else begin
            fin_st   = STAT_OK;
            fin_rate = q_round[RATE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ma     <= MA_W'(raw_src);
            r_sn     <= i_cfg.scale_num;
            r_acc_n  <= '0;
            r_da     <= DA_W'(i_cfg.audio_interval_rate);
            r_sd     <= i_cfg.scale_den;
            r_acc_d  <= '0;
            r_pre_st <= pre_st;
        end
        if (i_cmd.mul_step) begin
            if (r_sn[0]) begin
                r_acc_n <= r_acc_n + r_ma;
            end
            if (r_sd[0]) begin
                r_acc_d <= r_acc_d + r_da;
            end
            r_ma <= r_ma << 1;
            r_da <= r_da << 1;
            r_sn <= r_sn >> 1;
            r_sd <= r_sd >> 1;
        end
        if (i_cmd.div_init) begin
            r_den  <= DEN_W'(r_acc_d) << i_cfg.fraction_bits;
            r_num  <= {r_acc_n, {Q_FRAC{1'b0}}};
            r_rem  <= '0;
            r_q    <= '0;
            r_qovf <= 1'b0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
            r_num  <= r_num << 1;
            // quotient bits above bit 63 only matter as an overflow flag
            r_qovf <= r_qovf | r_q[RATE_W-1];
            r_q    <= {r_q[RATE_W-2:0], ge};
        end
        if (i_cmd.finish) begin
            r_rate   <= fin_rate;
            r_status <= fin_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    assign o_stat.pre_fail = (r_pre_st != STAT_OK);
    assign o_valid         = r_valid;
    assign o_rate_q32      = r_rate;
    assign o_status        = r_status;

    a_fail_zero_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status != STAT_OK) |-> (r_rate == '0))
        else $error("failed transaction carries a nonzero rate");

    a_ok_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == STAT_OK) |->
            (r_rate != '0 && r_rate <= i_cfg.max_rate))
        else $error("ok transaction rate outside accepted range");

endmodule

// File: bench/tb_feedback_rate_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_feedback_rate_normalizer
// Self-checking bench: a table of directed values, then random phases under
// several register settings, each result checked against its typed table
// entry or a wide-integer model of the Q32.32 rate conversion.
// ----------------------------------------------------------------------------
module tb_feedback_rate_normalizer import fbrn_pkg::*; ();

    localparam int WIDE_W      = 192;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 125;
    localparam int DRAIN_WAIT  = 200;

    // addresses past the last register, writes there must be dropped
    localparam logic [REG_IDX_W-1:0] REG_HOLE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_HOLE_HI = 3'd7;

    localparam t_cfg CFG_RESET = '{6'd16, 13'd1000, 13'd1000, 32'd1, 32'd1, '1};

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        t_status           status;
    } t_rate_exp;

    typedef struct {
        t_cfg              cfg;
        logic [RAW_W-1:0]  raw;
        bit                typed;
        logic [RATE_W-1:0] rate;
        t_status           status;
    } t_dir_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [RAW_W-1:0]  i_raw_value;
    logic              o_valid;
    logic [RATE_W-1:0] o_rate_q32;
    logic [1:0]        o_status;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // typed expectation travels with the transaction it belongs to
    logic              tbl_typed;
    logic [RATE_W-1:0] tbl_rate;
    t_status           tbl_status;

    t_cfg       cfg_shadow;
    t_rate_exp  pending_rates[$];
    t_rate_exp  got_exp;
    t_dir_row   dir_rows[$];
    t_dir_row   dir_row;
    t_cfg       c;
    int         err_cnt;
    int         cycle_cnt;
    int         idle_pct;
    int         bits;
    logic [RAW_W-1:0] raw;

    feedback_rate_normalizer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_raw_value (i_raw_value),
        .o_valid     (o_valid),
        .o_rate_q32  (o_rate_q32),
        .o_status    (o_status),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // argument checks, exact quotient with half-up rounding, then the width and range checks
    function automatic t_rate_exp normalize_rate(input logic [RAW_W-1:0] value, input t_cfg k);
        logic [WIDE_W-1:0] dividend;
        logic [WIDE_W-1:0] divisor;
        logic [WIDE_W-1:0] quo;
        logic [WIDE_W-1:0] rmd;
        t_rate_exp         r;
        r.rate = '0;
        if (value == 0 || k.source_interval_rate == 0 || k.audio_interval_rate == 0 ||
            k.scale_num == 0 || k.scale_den == 0) begin
            r.status = STAT_INVALID;
        end else if (k.source_interval_rate > RATE_LIMIT ||
                     k.audio_interval_rate > RATE_LIMIT) begin
            r.status = STAT_RANGE;
        end else begin
            dividend = (WIDE_W'(value) * k.source_interval_rate * k.scale_num) << Q_FRAC;
            divisor  = (WIDE_W'(k.audio_interval_rate) * k.scale_den) << k.fraction_bits;
            quo = dividend / divisor;
            rmd = dividend % divisor;
            if ((rmd << 1) >= divisor)
                quo = quo + 1;
            if (quo[WIDE_W-1:RATE_W] != 0) begin
                r.status = STAT_OVERFLOW;
            end else if (quo == 0 || quo[RATE_W-1:0] > k.max_rate) begin
                r.status = STAT_RANGE;
            end else begin
                r.rate   = quo[RATE_W-1:0];
                r.status = STAT_OK;
            end
        end
        return r;
    endfunction

    // one apb write followed by a read back of the same register
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] rd_exp;
        bit                known;
        known  = 1'b1;
        rd_exp = '0;
        case (idx)
            REG_FRAC_BITS: begin
                cfg_shadow.fraction_bits = value[FB_W-1:0];
                rd_exp = APB_DW'(cfg_shadow.fraction_bits);
            end
            REG_SRC_RATE: begin
                cfg_shadow.source_interval_rate = value[IRATE_W-1:0];
                rd_exp = APB_DW'(cfg_shadow.source_interval_rate);
            end
            REG_AUD_RATE: begin
                cfg_shadow.audio_interval_rate = value[IRATE_W-1:0];
                rd_exp = APB_DW'(cfg_shadow.audio_interval_rate);
            end
            REG_SCALE_NUM: begin
                cfg_shadow.scale_num = value[SCALE_W-1:0];
                rd_exp = APB_DW'(cfg_shadow.scale_num);
            end
            REG_SCALE_DEN: begin
                cfg_shadow.scale_den = value[SCALE_W-1:0];
                rd_exp = APB_DW'(cfg_shadow.scale_den);
            end
            REG_MAX_RATE: begin
                cfg_shadow.max_rate = value;
                rd_exp = value;
            end
            default: known = 1'b0;
        endcase
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (known && prdata !== rd_exp) begin
            err_cnt++;
            $display("%0t reg %0d read back: expected %h got %h", $time, idx, rd_exp, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_cfg(input t_cfg k);
        write_reg(REG_FRAC_BITS, APB_DW'(k.fraction_bits));
        write_reg(REG_SRC_RATE,  APB_DW'(k.source_interval_rate));
        write_reg(REG_AUD_RATE,  APB_DW'(k.audio_interval_rate));
        write_reg(REG_SCALE_NUM, APB_DW'(k.scale_num));
        write_reg(REG_SCALE_DEN, APB_DW'(k.scale_den));
        write_reg(REG_MAX_RATE,  k.max_rate);
    endtask

    // returns at the edge that takes the transaction, start still high
    task automatic issue_raw(input logic [RAW_W-1:0] value, input bit typed,
                             input logic [RATE_W-1:0] rate, input t_status status);
        start       <= 1'b1;
        i_raw_value <= value;
        tbl_typed   <= typed;
        tbl_rate    <= rate;
        tbl_status  <= status;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic hold_off(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_results_done();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_rates.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_rates.size() == 0) begin
                    err_cnt++;
                    $display("%0t unexpected result: expected none got rate %h status %0d",
                             $time, o_rate_q32, o_status);
                end else begin
                    got_exp = pending_rates.pop_front();
                    if (o_rate_q32 !== got_exp.rate) begin
                        err_cnt++;
                        $display("%0t rate_q32: expected %h got %h",
                                 $time, got_exp.rate, o_rate_q32);
                    end
                    if (o_status !== got_exp.status) begin
                        err_cnt++;
                        $display("%0t status: expected %0d got %0d",
                                 $time, got_exp.status, o_status);
                    end
                end
            end
            if (start && !busy) begin
                if (tbl_typed)
                    pending_rates.push_back(t_rate_exp'{tbl_rate, tbl_status});
                else
                    pending_rates.push_back(normalize_rate(i_raw_value, cfg_shadow));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_raw_value = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        tbl_typed   = 1'b0;
        tbl_rate    = '0;
        tbl_status  = STAT_OK;
        err_cnt     = 0;
        cycle_cnt   = 0;
        cfg_shadow  = CFG_RESET;

        // directed rows: reset values, rounding edges, boundaries, argument errors
        c = CFG_RESET;
        dir_rows.push_back('{c, 64'd0, 1'b1, 64'd0, STAT_INVALID});
        dir_rows.push_back('{c, 64'h1_0000, 1'b1, 64'h1_0000_0000, STAT_OK});
        dir_rows.push_back('{c, 64'd1, 1'b1, 64'h1_0000, STAT_OK});
        dir_rows.push_back('{c, '1, 1'b1, 64'd0, STAT_OVERFLOW});
        dir_rows.push_back('{c, 64'h8000_0000_0000_0000, 1'b1, 64'd0, STAT_OVERFLOW});
        dir_rows.push_back('{c, 64'hDEAD_BEEF, 1'b0, 64'd0, STAT_OK});
        c.fraction_bits = 6'd32;
        dir_rows.push_back('{c, 64'd1, 1'b1, 64'd1, STAT_OK});
        dir_rows.push_back('{c, '1, 1'b1, '1, STAT_OK});
        // exact halves round up
        c.fraction_bits = 6'd33;
        dir_rows.push_back('{c, 64'd1, 1'b1, 64'd1, STAT_OK});
        dir_rows.push_back('{c, 64'd3, 1'b1, 64'd2, STAT_OK});
        c.fraction_bits = 6'd34;
        dir_rows.push_back('{c, 64'd1, 1'b1, 64'd0, STAT_RANGE});
        c.fraction_bits = 6'd63;
        dir_rows.push_back('{c, 64'h8000_0000_0000_0000, 1'b1, 64'h1_0000_0000, STAT_OK});
        dir_rows.push_back('{c, 64'd1, 1'b1, 64'd0, STAT_RANGE});
        c = CFG_RESET;
        c.max_rate = 64'h1_0000_0000;
        dir_rows.push_back('{c, 64'h1_0000, 1'b1, 64'h1_0000_0000, STAT_OK});
        dir_rows.push_back('{c, 64'h1_0001, 1'b1, 64'd0, STAT_RANGE});
        c = CFG_RESET;
        c.source_interval_rate = '0;
        dir_rows.push_back('{c, 64'd1, 1'b1, 64'd0, STAT_INVALID});
        // zero check wins over the rate limit
        c.audio_interval_rate = '1;
        dir_rows.push_back('{c, 64'd1, 1'b1, 64'd0, STAT_INVALID});
        c = CFG_RESET;
        c.audio_interval_rate = '0;
        dir_rows.push_back('{c, 64'd1, 1'b1, 64'd0, STAT_INVALID});
        c = CFG_RESET;
        c.scale_num = '0;
        dir_rows.push_back('{c, 64'd1, 1'b1, 64'd0, STAT_INVALID});
        c = CFG_RESET;
        c.scale_den = '0;
        dir_rows.push_back('{c, 64'd1, 1'b1, 64'd0, STAT_INVALID});
        c = CFG_RESET;
        c.source_interval_rate = 13'd8001;
        dir_rows.push_back('{c, 64'd1, 1'b1, 64'd0, STAT_RANGE});
        c = CFG_RESET;
        c.audio_interval_rate = '1;
        dir_rows.push_back('{c, 64'd1, 1'b1, 64'd0, STAT_RANGE});
        // quotient just below and right at 2^64
        c = '{6'd0, 13'd8000, 13'd8000, 32'd1, 32'd1, '1};
        dir_rows.push_back('{c, 64'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_0000_0000, STAT_OK});
        dir_rows.push_back('{c, 64'h1_0000_0000, 1'b1, 64'd0, STAT_OVERFLOW});
        c = '{6'd0, 13'd8000, 13'd1, '1, 32'd1, '1};
        dir_rows.push_back('{c, 64'd1, 1'b1, 64'd0, STAT_OVERFLOW});
        c = '{6'd63, 13'd1, 13'd8000, 32'd1, '1, '1};
        dir_rows.push_back('{c, '1, 1'b0, 64'd0, STAT_OK});

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            dir_row = dir_rows[i];
            if (dir_row.cfg != cfg_shadow) begin
                wait_results_done();
                set_cfg(dir_row.cfg);
            end
            issue_raw(dir_row.raw, dir_row.typed, dir_row.rate, dir_row.status);
        end

        for (int ph = 0; ph < 6; ph++) begin
            idle_pct = (ph < 2) ? 32 : (ph < 4) ? 48 : 0;
            case (ph)
                0: c = '{6'($urandom_range(0, 63)), 13'($urandom_range(1, 8000)),
                         13'($urandom_range(1, 8000)), 32'($urandom_range(1, 1000)),
                         32'($urandom_range(1, 1000)), '1};
                1: c = '{6'd63, 13'd8000, 13'd1, '1, 32'd1, {$urandom, $urandom}};
                2: c = '{6'd0, 13'd1, 13'd8000, 32'd1, '1, '1};
                3: c = '{6'($urandom_range(0, 63)), 13'($urandom_range(1, 8191)),
                         13'($urandom_range(1, 8191)), 32'($urandom), 32'($urandom),
                         {$urandom, $urandom}};
                4: c = '{6'($urandom_range(0, 63)), 13'($urandom_range(1, 8000)),
                         13'($urandom_range(1, 8000)), 32'($urandom_range(1, 65535)),
                         32'($urandom_range(1, 65535)), {$urandom, $urandom}};
                default: begin
                    c = CFG_RESET;
                    c.max_rate = {$urandom, $urandom};
                end
            endcase
            wait_results_done();
            set_cfg(c);
            if (ph == 3) begin
                write_reg(REG_HOLE_LO, {$urandom, $urandom});
                write_reg(REG_HOLE_HI, {$urandom, $urandom});
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < idle_pct)
                    hold_off(($urandom_range(3) == 0) ? $urandom_range(1, 200)
                                                      : $urandom_range(1, 4));
                else if ($urandom_range(63) == 0)
                    wait_results_done();
                // random magnitude so results spread over ok, range and overflow
                bits = $urandom_range(0, 64);
                raw  = {$urandom, $urandom};
                if (bits < 64)
                    raw = raw & ((64'd1 << bits) - 64'd1);
                if (bits != 0)
                    raw[bits-1] = 1'b1;
                issue_raw(raw, 1'b0, '0, STAT_OK);
            end
        end

        wait_results_done();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_cnt == 0 && pending_rates.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
src/fbrn_pkg.sv
src/fbrn_regs.sv
src/fbrn_ctrl.sv
src/fbrn_dp.sv
src/feedback_rate_normalizer.sv
bench/tb_feedback_rate_normalizer.sv
